// File: src/fppi_pkg.sv
// Shared types and constants for the pulse peak / integral block.
// No dependencies; imported by every module of the block.
package fppi_pkg;

    localparam int OUT_CH  = 4;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    localparam logic [11:0] HDR_BYTES = 12'd32;
    localparam logic [11:0] LEN_BYTES = 12'd4;
    localparam logic [11:0] TRIG_POS  = 12'd6;
    localparam logic [12:0] MIN_LEN   = 13'd34;
    localparam logic [12:0] MAX_LEN   = 13'd4096;
    localparam logic [8:0]  MIN_PED   = 9'd1;
    localparam logic [8:0]  MAX_PED   = 9'd256;

    localparam logic [12:0] RST_RECORD_LENGTH    = 13'd2048;
    localparam logic [3:0]  RST_EXPECTED_TRIGGER = 4'd3;
    localparam logic [8:0]  RST_PEDESTAL_COUNT   = 9'd40;
    localparam logic [3:0]  RST_CHANNEL_ENABLE   = 4'd14;

    localparam logic [1:0] REG_RECORD_LENGTH    = 2'd0;
    localparam logic [1:0] REG_EXPECTED_TRIGGER = 2'd1;
    localparam logic [1:0] REG_PEDESTAL_COUNT   = 2'd2;
    localparam logic [1:0] REG_CHANNEL_ENABLE   = 2'd3;

    typedef struct packed {
        logic [12:0] record_length;
        logic [3:0]  expected_trigger;
        logic [8:0]  pedestal_count;
        logic [3:0]  channel_enable;
    } cfg_t;

    typedef struct packed {
        logic [11:0] smax;
        logic [19:0] ped;
        logic [22:0] ssum;
        logic        len_ok;
        logic        trig_ok;
    } lane_res_t;

    typedef struct packed {
        lane_res_t [OUT_CH-1:0] lane;
        logic [8:0]             ped_n;
        logic [10:0]            samples;
        logic [OUT_CH-1:0]      mask;
    } event_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUB,
        BK_HOLD
    } back_state_t;

endpackage

// File: src/fppi_front.sv
// Front end: header checks, sample unpacking and per-lane accumulation.
// Pushes one event summary per record with an enabled lane into the queue. Uses fppi_pkg.
module fppi_front #(
    parameter int LANES = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fppi_pkg::cfg_t            cfg,
    input  logic                      in_valid,
    input  logic [LANES-1:0][7:0]     in_bytes,
    output logic                      in_ready,
    input  logic                      q_full,
    output logic                      q_push,
    output fppi_pkg::event_t          q_data
);
    import fppi_pkg::*;

    localparam int OUT_LANES = (LANES < OUT_CH) ? LANES : OUT_CH;
    localparam logic [OUT_CH-1:0] LANE_MASK = OUT_CH'((1 << OUT_LANES) - 1);

    logic [11:0] pos_reg;
    logic [12:0] len_clamp;
    logic [12:0] eff_len;
    logic [12:0] len_minus_hdr;
    logic [10:0] samples;
    logic [8:0]  ped_clamp;
    logic [8:0]  ped_n;
    logic [11:0] pos_minus_hdr;
    logic [10:0] sample_idx;
    logic        is_final;
    logic        accept;
    lane_res_t [OUT_CH-1:0] lane_snap;

    always_comb begin
        if (cfg.record_length < MIN_LEN) begin
            len_clamp = MIN_LEN;
        end else if (cfg.record_length > MAX_LEN) begin
            len_clamp = MAX_LEN;
        end else begin
            len_clamp = cfg.record_length;
        end
        eff_len       = {len_clamp[12:1], 1'b0};
        len_minus_hdr = eff_len - {1'b0, HDR_BYTES};
        samples       = len_minus_hdr[11:1];
        if (cfg.pedestal_count < MIN_PED) begin
            ped_clamp = MIN_PED;
        end else if (cfg.pedestal_count > MAX_PED) begin
            ped_clamp = MAX_PED;
        end else begin
            ped_clamp = cfg.pedestal_count;
        end
        if ({2'b0, ped_clamp} > samples) begin
            ped_n = samples[8:0];
        end else begin
            ped_n = ped_clamp;
        end
        pos_minus_hdr = pos_reg - HDR_BYTES;
        sample_idx    = pos_minus_hdr[11:1];
        is_final      = ({1'b0, pos_reg} + 13'd1) >= eff_len;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && is_final && ((cfg.channel_enable & LANE_MASK) != '0);

    always_comb begin
        q_data.lane    = lane_snap;
        q_data.ped_n   = ped_n;
        q_data.samples = samples;
        q_data.mask    = cfg.channel_enable & LANE_MASK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (accept) begin
            pos_reg <= is_final ? '0 : pos_reg + 12'd1;
        end
    end

    for (genvar c = 0; c < OUT_CH; c++) begin : g_lane
        if (c < OUT_LANES) begin : g_act
            logic [31:0] lw_reg, lw_next;
            logic [3:0]  tn_reg, tn_next;
            logic [7:0]  hold_reg, hold_next;
            logic [19:0] ped_reg, ped_next;
            logic [22:0] sum_reg, sum_next;
            logic [11:0] max_reg, max_next;
            logic [11:0] smp;
            logic [7:0]  b;

            assign b   = in_bytes[c];
            assign smp = {b[3:0], hold_reg};

            always_comb begin
                lw_next   = lw_reg;
                tn_next   = tn_reg;
                hold_next = hold_reg;
                ped_next  = ped_reg;
                sum_next  = sum_reg;
                max_next  = max_reg;
                if (pos_reg < LEN_BYTES) begin
                    lw_next[8*pos_reg[1:0] +: 8] = b;
                end else if (pos_reg == TRIG_POS) begin
                    tn_next = b[3:0];
                end else if (pos_reg >= HDR_BYTES) begin
                    if (!pos_reg[0]) begin
                        hold_next = b;
                    end else if (sample_idx < samples) begin
                        if (sample_idx < {2'b0, ped_n}) begin
                            ped_next = ped_reg + 20'(smp);
                        end
                        sum_next = sum_reg + 23'(smp);
                        if (smp > max_reg) begin
                            max_next = smp;
                        end
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    lw_reg  <= '0;
                    tn_reg  <= '0;
                    ped_reg <= '0;
                    sum_reg <= '0;
                    max_reg <= '0;
                end else if (accept) begin
                    lw_reg <= lw_next;
                    tn_reg <= tn_next;
                    if (is_final) begin
                        ped_reg <= '0;
                        sum_reg <= '0;
                        max_reg <= '0;
                    end else begin
                        ped_reg <= ped_next;
                        sum_reg <= sum_next;
                        max_reg <= max_next;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (accept) begin
                    hold_reg <= hold_next;
                end
            end

            always_comb begin
                lane_snap[c].smax    = max_next;
                lane_snap[c].ped     = ped_next;
                lane_snap[c].ssum    = sum_next;
                lane_snap[c].len_ok  = (lw_next == {19'b0, eff_len});
                lane_snap[c].trig_ok = (tn_next == cfg.expected_trigger);
            end
        end else begin : g_off
            assign lane_snap[c] = '0;
        end
    end

endmodule

// File: src/fppi_queue.sv
// Two-entry event queue between front end and result engine.
// Uses fppi_pkg for the event type and depth.
module fppi_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fppi_pkg::event_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output fppi_pkg::event_t  head
);
    import fppi_pkg::*;

    event_t             mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;

    assign full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: src/fppi_back.sv
// Result engine: walks enabled channels of the queue head, scales
// peak and integral, and drives the result register. Uses fppi_pkg.
module fppi_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  fppi_pkg::event_t  q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_channel,
    output logic [19:0]       out_peak,
    output logic [31:0]       out_integral,
    output logic              out_len_ok,
    output logic              out_trig_ok,
    output logic              out_last
);
    import fppi_pkg::*;

    back_state_t state_reg, state_next;

    logic [OUT_CH-1:0] rem_reg;
    logic [1:0]        ch_sel;
    logic [OUT_CH-1:0] ch_onehot;
    lane_res_t         sel;
    logic              load_mask, do_mul, do_sub;

    logic [1:0]  ch_reg;
    logic [20:0] prod_pk_reg;
    logic [19:0] ped_reg;
    logic [31:0] prod_a_reg;
    logic [30:0] prod_b_reg;
    logic        len_ok_reg, trig_ok_reg, last_reg;
    logic [21:0] pk_diff;

    always_comb begin
        ch_sel = '0;
        for (int i = OUT_CH - 1; i >= 0; i--) begin
            if (rem_reg[i]) begin
                ch_sel = 2'(i);
            end
        end
        ch_onehot = OUT_CH'(1) << ch_sel;
        sel       = q_head.lane[ch_sel];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_SUB;
            BK_SUB:  state_next = BK_HOLD;
            BK_HOLD: begin
                if (out_ready) begin
                    state_next = last_reg ? BK_IDLE : BK_MUL;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        load_mask = 1'b0;
        do_mul    = 1'b0;
        do_sub    = 1'b0;
        q_pop     = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            BK_IDLE: load_mask = !q_empty;
            BK_MUL:  do_mul = 1'b1;
            BK_SUB:  do_sub = 1'b1;
            BK_HOLD: begin
                out_valid = 1'b1;
                q_pop     = out_ready && last_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            rem_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_mask) begin
                rem_reg <= q_head.mask;
            end else if (do_mul) begin
                rem_reg  <= rem_reg & ~ch_onehot;
                last_reg <= ((rem_reg & ~ch_onehot) == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_mul) begin
            ch_reg      <= ch_sel;
            prod_pk_reg <= 21'(q_head.ped_n) * 21'(sel.smax);
            ped_reg     <= sel.ped;
            prod_a_reg  <= 32'(q_head.ped_n) * 32'(sel.ssum);
            prod_b_reg  <= 31'(q_head.samples) * 31'(sel.ped);
            len_ok_reg  <= sel.len_ok;
            trig_ok_reg <= sel.trig_ok;
        end
    end

    assign pk_diff = {1'b0, prod_pk_reg} - {2'b0, ped_reg};

    always_ff @(posedge aclk) begin
        if (do_sub) begin
            out_channel  <= ch_reg;
            out_peak     <= pk_diff[21] ? 20'd0 : pk_diff[19:0];
            out_integral <= prod_a_reg - {1'b0, prod_b_reg};
            out_len_ok   <= len_ok_reg;
            out_trig_ok  <= trig_ok_reg;
        end
    end

    assign out_last = last_reg;

endmodule

// File: src/fadc_pulse_peak_integral.sv
// Pulse peak and integral for interleaved digitizer lanes.
// Throughput: one beat per cycle; the front end stalls only if two record
// summaries wait in the event queue. Each queued record goes through the
// result engine's multiply, subtract and hold steps once per enabled channel;
// each result is held until m_tready takes it. aresetn (synchronous) restores the
// register defaults, empties the queue and restarts at record byte zero.
module fadc_pulse_peak_integral #(
    parameter int LANES = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [8*LANES-1:0]   s_tdata,   // lane0_byte, lane1_byte, ... one byte per lane
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,   // peak_scaled[19:0], integral_scaled[51:20], zero pad
    output logic [3:0]           m_tuser,   // channel[1:0], length_ok[2], trigger_ok[3]
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import fppi_pkg::*;

    cfg_t   cfg_reg;
    event_t q_in, q_head;
    logic   q_push, q_pop, q_full, q_empty;
    logic   cfg_wr;
    logic [LANES-1:0][7:0] lane_bytes;
    logic [1:0]  r_ch;
    logic [19:0] r_peak;
    logic [31:0] r_integ;
    logic        r_lok, r_tok;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.record_length    <= RST_RECORD_LENGTH;
            cfg_reg.expected_trigger <= RST_EXPECTED_TRIGGER;
            cfg_reg.pedestal_count   <= RST_PEDESTAL_COUNT;
            cfg_reg.channel_enable   <= RST_CHANNEL_ENABLE;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RECORD_LENGTH:    cfg_reg.record_length    <= pwdata[12:0];
                REG_EXPECTED_TRIGGER: cfg_reg.expected_trigger <= pwdata[3:0];
                REG_PEDESTAL_COUNT:   cfg_reg.pedestal_count   <= pwdata[8:0];
                REG_CHANNEL_ENABLE:   cfg_reg.channel_enable   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RECORD_LENGTH:    prdata = 32'(cfg_reg.record_length);
            REG_EXPECTED_TRIGGER: prdata = 32'(cfg_reg.expected_trigger);
            REG_PEDESTAL_COUNT:   prdata = 32'(cfg_reg.pedestal_count);
            REG_CHANNEL_ENABLE:   prdata = 32'(cfg_reg.channel_enable);
            default:              prdata = '0;
        endcase
    end

    assign lane_bytes = s_tdata;

    fppi_front #(
        .LANES(LANES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_bytes (lane_bytes),
        .in_ready (s_tready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    fppi_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    fppi_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_channel  (r_ch),
        .out_peak     (r_peak),
        .out_integral (r_integ),
        .out_len_ok   (r_lok),
        .out_trig_ok  (r_tok),
        .out_last     (m_tlast)
    );

    assign m_tdata = {4'b0, r_integ, r_peak};
    assign m_tuser = {r_tok, r_lok, r_ch};

endmodule

// File: tb/fadc_pulse_peak_integral_tb.sv
// Self-checking testbench for fadc_pulse_peak_integral: streams four-lane record
// bytes, predicts per-channel peak/integral results and compares every result beat.
// Depends on fppi_pkg and the RTL under src/.
module fadc_pulse_peak_integral_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fppi_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BEATS   = 60;
    localparam int IDLE_PCT       = 6;

    typedef enum logic [1:0] {
        SMP_RANDOM,
        SMP_PULSE,
        SMP_FULL,
        SMP_ZERO
    } sample_style_t;

    typedef struct {
        logic [1:0]  channel;
        logic [19:0] peak;
        logic [31:0] integral;
        logic        len_ok;
        logic        trig_ok;
        logic        last;
    } pulse_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the block's registers and per-lane record state
    logic [12:0] cfg_len  = RST_RECORD_LENGTH;
    logic [3:0]  cfg_trig = RST_EXPECTED_TRIGGER;
    logic [8:0]  cfg_ped  = RST_PEDESTAL_COUNT;
    logic [3:0]  cfg_en   = RST_CHANNEL_ENABLE;

    int unsigned record_pos = 0;
    logic [31:0] len_word [4] = '{default: '0};
    logic [3:0]  trig_nib [4] = '{default: '0};
    logic [7:0]  low_hold [4] = '{default: '0};
    logic [19:0] ped_sum  [4] = '{default: '0};
    logic [22:0] smp_sum  [4] = '{default: '0};
    logic [11:0] smp_max  [4] = '{default: '0};

    pulse_result_t expected_results [$];
    pulse_result_t exp_r;

    int idle_pct     = IDLE_PCT;
    int errors       = 0;
    int beats_sent   = 0;
    int stall_cycles = 0;

    fadc_pulse_peak_integral #(.LANES(4)) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= idle_pct);
    end

    function automatic int unsigned eff_len(logic [12:0] l);
        int unsigned v;
        v = 32'(l);
        if (v < MIN_LEN) v = MIN_LEN;
        if (v > MAX_LEN) v = MAX_LEN;
        return v & ~32'd1;
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    task automatic predict_beat(input logic [31:0] d);
        int unsigned   len, samples, n, p, a;
        int            last_c;
        logic [7:0]    b;
        logic [11:0]   s;
        longint        pk, integ;
        pulse_result_t r;
        len     = eff_len(cfg_len);
        samples = (len - HDR_BYTES) / 2;
        n       = 32'(cfg_ped);
        if (n < MIN_PED) n = MIN_PED;
        if (n > MAX_PED) n = MAX_PED;
        if (n > samples) n = samples;
        p = record_pos;
        for (int c = 0; c < 4; c++) begin
            b = d[8*c +: 8];
            if (p < LEN_BYTES) begin
                len_word[c][8*p +: 8] = b;
            end else if (p == TRIG_POS) begin
                trig_nib[c] = b[3:0];
            end else if (p >= HDR_BYTES) begin
                if (p % 2 == 0) begin
                    low_hold[c] = b;
                end else begin
                    a = (p - HDR_BYTES) / 2;
                    s = {b[3:0], low_hold[c]};
                    if (a < samples) begin
                        if (a < n) ped_sum[c] = ped_sum[c] + 20'(s);
                        smp_sum[c] = smp_sum[c] + 23'(s);
                        if (s > smp_max[c]) smp_max[c] = s;
                    end
                end
            end
        end
        if (p + 1 >= len) begin
            last_c = -1;
            for (int c = 0; c < 4; c++) if (cfg_en[c]) last_c = c;
            for (int c = 0; c < 4; c++) begin
                if (cfg_en[c]) begin
                    pk = longint'(n) * longint'(smp_max[c]) - longint'(ped_sum[c]);
                    if (pk < 0) pk = 0;
                    integ = longint'(n) * longint'(smp_sum[c])
                          - longint'(samples) * longint'(ped_sum[c]);
                    r.channel  = 2'(c);
                    r.peak     = pk[19:0];
                    r.integral = integ[31:0];
                    r.len_ok   = (len_word[c] == len);
                    r.trig_ok  = (trig_nib[c] == cfg_trig);
                    r.last     = (c == last_c);
                    expected_results.push_back(r);
                end
                ped_sum[c] = '0;
                smp_sum[c] = '0;
                smp_max[c] = '0;
            end
            record_pos = 0;
        end else begin
            record_pos = (p + 1) & 32'hFFF;
        end
    endtask

    task automatic send_beat(input logic [31:0] d);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(d);
        beats_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_RECORD_LENGTH:    cfg_len  = val[12:0];
            REG_EXPECTED_TRIGGER: cfg_trig = val[3:0];
            REG_PEDESTAL_COUNT:   cfg_ped  = val[8:0];
            REG_CHANNEL_ENABLE:   cfg_en   = val[3:0];
            default: ;
        endcase
    endtask

    task automatic reg_read(input logic [1:0] idx, output logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [12:0] len, input logic [3:0] trig,
                             input logic [8:0] ped, input logic [3:0] en);
        drain();
        reg_write(REG_RECORD_LENGTH, 32'(len));
        reg_write(REG_EXPECTED_TRIGGER, 32'(trig));
        reg_write(REG_PEDESTAL_COUNT, 32'(ped));
        reg_write(REG_CHANNEL_ENABLE, 32'(en));
    endtask

    function automatic logic [11:0] gen_sample(sample_style_t st, int unsigned a,
                                               int unsigned samples);
        int unsigned v;
        case (st)
            SMP_RANDOM: v = $urandom_range(4095);
            SMP_PULSE: begin
                v = 300 + $urandom_range(20);
                if (a >= samples / 2 && a < samples / 2 + 4) v = v + $urandom_range(3795);
            end
            SMP_FULL: v = 4095;
            default:  v = 0;
        endcase
        return v[11:0];
    endfunction

    // header carries the right length/trigger unless faulted; lane c uses styles[2c+:2]
    task automatic send_record(input int unsigned fault_pct, input logic [7:0] styles);
        int unsigned len, samples;
        logic [31:0] lenw [4];
        logic [3:0]  trig [4];
        logic [11:0] smp  [4];
        logic [31:0] d;
        logic [7:0]  b;
        len     = eff_len(cfg_len);
        samples = (len - HDR_BYTES) / 2;
        for (int c = 0; c < 4; c++) begin
            lenw[c] = len;
            trig[c] = cfg_trig;
            if ($urandom_range(99) < fault_pct) begin
                if ($urandom_range(1)) lenw[c] = lenw[c] ^ (32'h1 << $urandom_range(31));
                else lenw[c] = $urandom;
            end
            if ($urandom_range(99) < fault_pct) trig[c] = trig[c] ^ 4'($urandom_range(1, 15));
        end
        for (int unsigned p = 0; p < len; p++) begin
            for (int c = 0; c < 4; c++) begin
                if (p < LEN_BYTES) begin
                    b = lenw[c][8*p +: 8];
                end else if (p == TRIG_POS) begin
                    b = {4'($urandom_range(15)), trig[c]};
                end else if (p < HDR_BYTES) begin
                    b = 8'($urandom_range(255));
                end else if (p % 2 == 0) begin
                    smp[c] = gen_sample(sample_style_t'(styles[2*c +: 2]),
                                        (p - HDR_BYTES) / 2, samples);
                    b = smp[c][7:0];
                end else begin
                    b = {4'($urandom_range(15)), smp[c][11:8]};
                end
                d[8*c +: 8] = b;
            end
            send_beat(d);
        end
    endtask

    // defaults are read back; the record length is then shortened to keep the run brief
    task automatic test_reset_defaults();
        logic [31:0] v;
        reg_read(REG_RECORD_LENGTH, v);
        check_field("record_length", 32'(RST_RECORD_LENGTH), v);
        reg_read(REG_EXPECTED_TRIGGER, v);
        check_field("expected_trigger", 32'(RST_EXPECTED_TRIGGER), v);
        reg_read(REG_PEDESTAL_COUNT, v);
        check_field("pedestal_count", 32'(RST_PEDESTAL_COUNT), v);
        reg_read(REG_CHANNEL_ENABLE, v);
        check_field("channel_enable", 32'(RST_CHANNEL_ENABLE), v);
        reg_write(REG_RECORD_LENGTH, 32'd64);
        idle_pct = 0;
        send_record(10, 8'($urandom));
        idle_pct = IDLE_PCT;
    endtask

    task automatic test_minimum_record();
        configure(13'd34, 4'd0, 9'd1, 4'hF);
        send_record(0, {SMP_PULSE, SMP_RANDOM, SMP_FULL, SMP_ZERO});
        configure(13'd34, 4'd15, 9'd256, 4'hF);
        send_record(0, {SMP_ZERO, SMP_FULL, SMP_RANDOM, SMP_FULL});
    endtask

    task automatic test_header_faults();
        configure(13'd36, 4'd5, 9'd4, 4'hF);
        send_record(100, 8'($urandom));
        send_record(50, 8'($urandom));
    endtask

    task automatic test_config_clamping();
        configure(13'd0, 4'd9, 9'd0, 4'hF);
        send_record(10, 8'($urandom));
        configure(13'd41, 4'd3, 9'd511, 4'h5);
        send_record(10, {SMP_PULSE, SMP_FULL, SMP_RANDOM, SMP_PULSE});
    endtask

    task automatic test_no_channels();
        configure(13'd34, 4'd3, 9'd2, 4'h0);
        send_record(10, 8'($urandom));
        configure(13'd34, 4'd3, 9'd2, 4'h8);
        send_record(10, 8'($urandom));
    endtask

    task automatic test_random_records();
        int          start_beats, r;
        logic [12:0] len;
        logic [8:0]  ped;
        start_beats = beats_sent;
        r = 0;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            if (r == 0 || $urandom_range(99) < 30) begin
                r = $urandom_range(99);
                if (r < 5)       len = 13'($urandom_range(91, 130));
                else if (r < 12) len = 13'($urandom_range(0, 40));
                else             len = 13'($urandom_range(34, 90));
                if ($urandom_range(99) < 70) ped = 9'($urandom_range(0, 40));
                else                         ped = 9'($urandom_range(0, 511));
                configure(len, 4'($urandom_range(15)), ped, 4'($urandom_range(15)));
                r = 1;
            end
            if ($urandom_range(99) < 85) send_record(10, 8'($urandom));
            else                         send_record(100, 8'($urandom));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat on channel %0d with nothing expected", m_tuser[1:0]);
                errors++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("channel", 32'(exp_r.channel), 32'(m_tuser[1:0]));
                check_field("peak_scaled", 32'(exp_r.peak), 32'(m_tdata[19:0]));
                if (exp_r.integral !== m_tdata[51:20]) begin
                    $error("integral_scaled mismatch: expected %0d, got %0d",
                           $signed(exp_r.integral), $signed(m_tdata[51:20]));
                    errors++;
                end
                check_field("length_ok", 32'(exp_r.len_ok), 32'(m_tuser[2]));
                check_field("trigger_ok", 32'(exp_r.trig_ok), 32'(m_tuser[3]));
                check_field("last", 32'(exp_r.last), 32'(m_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("fadc_pulse_peak_integral test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_minimum_record();
        test_header_faults();
        test_config_clamping();
        test_no_channels();
        test_random_records();
        drain();
        if (errors == 0 && expected_results.size() == 0) begin
            $display("fadc_pulse_peak_integral test passed");
        end else begin
            $display("fadc_pulse_peak_integral test failed");
        end
        $finish;
    end

endmodule
